// File: rtl/core/sm4_pkg.sv
// SM4 cipher types, constants, S-box table and round helper functions.
package sm4_pkg;

   localparam int unsigned ROUND_COUNT = 32;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned ROUND_W     = $clog2(ROUND_COUNT);

   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_COUNT - 1);

   localparam logic OP_KEY_LOAD = 1'b0;
   localparam logic OP_ENCRYPT  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DONE
   } sm4_state_type;

   typedef logic [WORD_W-1:0] sm4_word_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
      8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
      8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
      8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
      8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
      8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
      8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
      8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
      8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
      8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
      8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
      8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
      8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
      8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
      8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
      8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
      8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
      8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
      8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
      8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
      8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
      8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
      8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
      8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
      8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
      8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
      8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
      8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
      8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
      8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
      8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
      8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
   };

   // Nonlinear layer: S-box on each byte
   function automatic sm4_word_type sm4_tau(input sm4_word_type a);
      sm4_word_type b;
      b[31:24] = SBOX[a[31:24]];
      b[23:16] = SBOX[a[23:16]];
      b[15:8]  = SBOX[a[15:8]];
      b[7:0]   = SBOX[a[7:0]];
      return b;
   endfunction

   // Linear layer: b ^ rol2 ^ rol10 ^ rol18 ^ rol24
   function automatic sm4_word_type sm4_lin(input sm4_word_type b);
      return b
         ^ {b[29:0], b[31:30]}
         ^ {b[21:0], b[31:22]}
         ^ {b[13:0], b[31:14]}
         ^ {b[7:0],  b[31:8]};
   endfunction

endpackage

// File: rtl/core/sm4_block_encrypt.sv
// SM4 block encryption engine with a 32-word round key store.
//
// A key-load transaction (opcode 0) writes one round-key word and produces no
// response. An encrypt transaction (opcode 1) runs the 32 SM4 rounds through a
// single shared round unit, one round per clock, with round keys read in order
// from the key store (registered read, prefetched one round ahead). The
// response is raised in ST_DONE, entered from the last round, and holds until
// accepted; the next request is taken in the cycle after the response
// handshake. Round keys must all be loaded before the first encryption; slots
// never written since reset hold unknown values.
module sm4_block_encrypt
   import sm4_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [ROUND_W-1:0]  req_key_slot,
   input  logic [WORD_W-1:0]   req_key_word,
   input  logic [WORD_W-1:0]   req_plain_w0,
   input  logic [WORD_W-1:0]   req_plain_w1,
   input  logic [WORD_W-1:0]   req_plain_w2,
   input  logic [WORD_W-1:0]   req_plain_w3,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_cipher_w0,
   output logic [WORD_W-1:0]   rsp_cipher_w1,
   output logic [WORD_W-1:0]   rsp_cipher_w2,
   output logic [WORD_W-1:0]   rsp_cipher_w3
);

   sm4_state_type       state_ff, state_in;
   logic [ROUND_W-1:0]  round_ff, round_in;

   sm4_word_type        x0_ff, x1_ff, x2_ff, x3_ff;
   sm4_word_type        x0_in, x1_in, x2_in, x3_in;

   sm4_word_type        key_store_ff [ROUND_COUNT];
   sm4_word_type        rkey_ff;
   logic [ROUND_W-1:0]  key_rd_addr;
   logic                key_we;

   logic                req_take;
   logic                rsp_take;
   sm4_word_type        round_out;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign key_we   = req_take && (req_opcode == OP_KEY_LOAD);

   // Prefetch key for round 0 while idle, then the following round's key
   assign key_rd_addr = (state_ff == ST_IDLE) ? '0 : round_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_store_ff[req_key_slot] <= req_key_word;
      end
      rkey_ff <= key_store_ff[key_rd_addr];
   end

   // Shared round unit
   assign round_out = x0_ff ^ sm4_lin(sm4_tau(x1_ff ^ x2_ff ^ x3_ff ^ rkey_ff));

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            round_in = '0;
            if (req_take && (req_opcode == OP_ENCRYPT)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_ROUND: req_ready = 1'b0;
         ST_DONE:  rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      x0_in = x0_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      x3_in = x3_ff;
      if (req_take && (req_opcode == OP_ENCRYPT)) begin
         x0_in = req_plain_w0;
         x1_in = req_plain_w1;
         x2_in = req_plain_w2;
         x3_in = req_plain_w3;
      end else if (state_ff == ST_ROUND) begin
         x0_in = x1_ff;
         x1_in = x2_ff;
         x2_in = x3_ff;
         x3_in = round_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      x3_ff <= x3_in;
   end

   // Ciphertext is the final state in reverse word order
   assign rsp_cipher_w0 = x3_ff;
   assign rsp_cipher_w1 = x2_ff;
   assign rsp_cipher_w2 = x1_ff;
   assign rsp_cipher_w3 = x0_ff;

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while response pending");

   a_encrypt_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_ENCRYPT))
      |=> (state_ff == ST_ROUND) && (round_ff == '0))
      else $error("encrypt did not start at round zero");

   a_last_round_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROUND) && (round_ff == LAST_ROUND)) |=> rsp_valid)
      else $error("response not raised after last round");

   a_key_load_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_KEY_LOAD)) |=> req_ready)
      else $error("key load left the engine busy");
`endif

endmodule

// File: tb/sv/sm4_block_encrypt_checker.sv
// Scoreboard for sm4_block_encrypt: mirrors the round key store and checks each cipher block.
`timescale 1ns / 1ps

module sm4_block_encrypt_checker
   import sm4_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_opcode,
   input  logic [ROUND_W-1:0]  req_key_slot,
   input  logic [WORD_W-1:0]   req_key_word,
   input  logic [WORD_W-1:0]   req_plain_w0,
   input  logic [WORD_W-1:0]   req_plain_w1,
   input  logic [WORD_W-1:0]   req_plain_w2,
   input  logic [WORD_W-1:0]   req_plain_w3,

   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [WORD_W-1:0]   rsp_cipher_w0,
   input  logic [WORD_W-1:0]   rsp_cipher_w1,
   input  logic [WORD_W-1:0]   rsp_cipher_w2,
   input  logic [WORD_W-1:0]   rsp_cipher_w3,

   output int                  fail_count,
   output int                  pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      sm4_word_type w0;
      sm4_word_type w1;
      sm4_word_type w2;
      sm4_word_type w3;
   } cipher_block_type;

   // GB/T 32907 substitution table
   localparam logic [7:0] SUBST [256] = '{
      8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
      8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
      8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
      8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
      8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
      8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
      8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
      8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
      8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
      8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
      8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
      8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
      8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
      8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
      8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
      8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
      8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
      8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
      8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
      8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
      8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
      8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
      8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
      8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
      8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
      8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
      8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
      8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
      8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
      8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
      8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
      8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
   };

   sm4_word_type     round_key [ROUND_COUNT];
   cipher_block_type cipher_q [$];
   int               mismatches = 0;

   function automatic sm4_word_type substitute_word(input sm4_word_type a);
      sm4_word_type s;
      for (int i = 0; i < 4; i++) begin
         s[8*i +: 8] = SUBST[a[8*i +: 8]];
      end
      return s;
   endfunction

   function automatic sm4_word_type rotate_left(input sm4_word_type v, input int n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic sm4_word_type diffuse(input sm4_word_type b);
      return b ^ rotate_left(b, 2) ^ rotate_left(b, 10) ^ rotate_left(b, 18)
               ^ rotate_left(b, 24);
   endfunction

   function automatic cipher_block_type encrypt_block(input sm4_word_type p0,
                                                      input sm4_word_type p1,
                                                      input sm4_word_type p2,
                                                      input sm4_word_type p3);
      sm4_word_type     x [4];
      sm4_word_type     t;
      cipher_block_type c;
      x = '{p0, p1, p2, p3};
      for (int r = 0; r < ROUND_COUNT; r++) begin
         t    = x[0] ^ diffuse(substitute_word(x[1] ^ x[2] ^ x[3] ^ round_key[r]));
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = t;
      end
      // output words come out in reverse order
      c.w0 = x[3];
      c.w1 = x[2];
      c.w2 = x[1];
      c.w3 = x[0];
      return c;
   endfunction

   always @(posedge clock) begin
      cipher_block_type got;
      cipher_block_type want;
      if (!reset) begin
         // response side first, so a result never matches a transaction taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_cipher_w0, rsp_cipher_w1, rsp_cipher_w2, rsp_cipher_w3};
            if (cipher_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("[%0t] unexpected cipher block %08h %08h %08h %08h", $realtime,
                           got.w0, got.w1, got.w2, got.w3);
               end
            end else begin
               want = cipher_q.pop_front();
               if (got.w0 !== want.w0 || got.w1 !== want.w1 ||
                   got.w2 !== want.w2 || got.w3 !== want.w3) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("[%0t] cipher mismatch: expected %08h %08h %08h %08h",
                              $realtime, want.w0, want.w1, want.w2, want.w3);
                     $display("[%0t]                  got      %08h %08h %08h %08h",
                              $realtime, got.w0, got.w1, got.w2, got.w3);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_KEY_LOAD) begin
               round_key[req_key_slot] = req_key_word;
            end else begin
               cipher_q.push_back(encrypt_block(req_plain_w0, req_plain_w1,
                                                req_plain_w2, req_plain_w3));
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= cipher_q.size();
   end

endmodule

// File: tb/sv/sm4_block_encrypt_tb.sv
// Top-level testbench for sm4_block_encrypt: clock, reset, stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module sm4_block_encrypt_tb
   import sm4_pkg::*;
();

   localparam realtime HALF_PERIOD = 6ns;
   localparam int      RESET_CYCLES = 7;
   localparam int      RANDOM_ITEMS = 1950;
   localparam int      IDLE_LIMIT   = 2000;
   localparam int      DRAIN_CYCLES = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_opcode = OP_KEY_LOAD;
   logic [ROUND_W-1:0]  req_key_slot = '0;
   sm4_word_type        req_key_word = '0;
   sm4_word_type        req_plain_w0 = '0;
   sm4_word_type        req_plain_w1 = '0;
   sm4_word_type        req_plain_w2 = '0;
   sm4_word_type        req_plain_w3 = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   sm4_word_type        rsp_cipher_w0;
   sm4_word_type        rsp_cipher_w1;
   sm4_word_type        rsp_cipher_w2;
   sm4_word_type        rsp_cipher_w3;

   int                  fail_count;
   int                  pending_count;

   int                  send_burst_left = 0;
   int                  sink_hold_left  = 0;
   int                  sink_burst_left = 0;
   int                  quiet_cycles    = 0;

   always #(HALF_PERIOD) clock = ~clock;

   sm4_block_encrypt DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_key_slot  (req_key_slot),
      .req_key_word  (req_key_word),
      .req_plain_w0  (req_plain_w0),
      .req_plain_w1  (req_plain_w1),
      .req_plain_w2  (req_plain_w2),
      .req_plain_w3  (req_plain_w3),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cipher_w0 (rsp_cipher_w0),
      .rsp_cipher_w1 (rsp_cipher_w1),
      .rsp_cipher_w2 (rsp_cipher_w2),
      .rsp_cipher_w3 (rsp_cipher_w3)
   );

   sm4_block_encrypt_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_key_slot  (req_key_slot),
      .req_key_word  (req_key_word),
      .req_plain_w0  (req_plain_w0),
      .req_plain_w1  (req_plain_w1),
      .req_plain_w2  (req_plain_w2),
      .req_plain_w3  (req_plain_w3),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cipher_w0 (rsp_cipher_w0),
      .rsp_cipher_w1 (rsp_cipher_w1),
      .rsp_cipher_w2 (rsp_cipher_w2),
      .rsp_cipher_w3 (rsp_cipher_w3),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // mostly short, now and then long
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic sm4_word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Presents one transaction, waits for the handshake, then may idle for a random gap.
   task automatic send_item(input logic op, input logic [ROUND_W-1:0] slot,
                            input sm4_word_type kw, input sm4_word_type p0,
                            input sm4_word_type p1, input sm4_word_type p2,
                            input sm4_word_type p3);
      int gap;
      int roll;
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_key_slot <= slot;
      req_key_word <= kw;
      req_plain_w0 <= p0;
      req_plain_w1 <= p1;
      req_plain_w2 <= p2;
      req_plain_w3 <= p3;
      do @(posedge clock); while (!req_ready);
      if (send_burst_left > 0) begin
         send_burst_left--;
         gap = 0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) send_burst_left = $urandom_range(20, 60);
         gap = (roll < 50) ? 0 : draw_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_key(input logic [ROUND_W-1:0] slot, input sm4_word_type kw);
      send_item(OP_KEY_LOAD, slot, kw, $urandom(), $urandom(), $urandom(), $urandom());
   endtask

   task automatic encrypt(input sm4_word_type p0, input sm4_word_type p1,
                          input sm4_word_type p2, input sm4_word_type p3);
      send_item(OP_ENCRYPT, ROUND_W'($urandom_range(0, ROUND_COUNT - 1)), $urandom(),
                p0, p1, p2, p3);
   endtask

   // response stalls land on any phase, with occasional long stretches of ready
   always @(posedge clock) begin
      int roll;
      if (sink_hold_left > 0) begin
         sink_hold_left--;
         rsp_ready <= 1'b0;
      end else if (sink_burst_left > 0) begin
         sink_burst_left--;
         rsp_ready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            sink_burst_left = $urandom_range(100, 400);
            rsp_ready <= 1'b1;
         end else if (roll < 22) begin
            sink_hold_left = draw_gap() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, quiet_cycles);
            $display("** sm4_block_encrypt: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int count;
      int roll;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // every slot must hold a key before the first encryption
      load_key('0, '0);
      for (int s = 1; s < ROUND_COUNT - 1; s++) load_key(ROUND_W'(s), $urandom());
      load_key(LAST_ROUND, '1);

      // directed: extreme blocks, ignored fields at extremes, key overwrite at both ends
      send_item(OP_ENCRYPT, '0, '0, '0, '0, '0, '0);
      send_item(OP_ENCRYPT, '1, '1, '1, '1, '1, '1);
      encrypt(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
      send_item(OP_KEY_LOAD, LAST_ROUND, '0, '1, '1, '1, '1);
      send_item(OP_KEY_LOAD, '0, '1, '0, '0, '0, '0);
      encrypt(32'h80000000, 32'h00000001, 32'haaaaaaaa, 32'h55555555);
      encrypt('1, '0, '1, '0);
      load_key(ROUND_W'(16), 32'ha5a5a5a5);
      encrypt('0, '1, '0, '1);

      count = 0;
      while (count < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            // fresh key schedule, then traffic on it
            for (int s = 0; s < ROUND_COUNT; s++) load_key(ROUND_W'(s), pick_word());
            count += ROUND_COUNT;
         end else if (roll < 40) begin
            load_key(ROUND_W'($urandom_range(0, ROUND_COUNT - 1)), pick_word());
            count++;
         end else begin
            encrypt(pick_word(), pick_word(), pick_word(), pick_word());
            count++;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("** sm4_block_encrypt: PASSED **");
      end else begin
         $display("** sm4_block_encrypt: FAILED **");
      end
      $finish;
   end

endmodule
